FILE: sv/fsc_pkg.sv
// Package for the fan speed control tick block: widths, constants and
// register indexes for the top level; the serial divider uses its widths.
// Depends on nothing.
package fsc_pkg;

   // Depth of the moving average of accepted speeds.
   localparam int AVG_DEPTH = 20;

   localparam int SPEED_W  = 12;
   localparam int TACHO_W  = 16;
   localparam int TEMP_W   = 8;
   localparam int DIAL_W   = 8;
   localparam int PW_W     = 9;
   localparam int GAIN_W   = 8;

   localparam int SLOT_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int CNT_W    = $clog2(AVG_DEPTH + 1);
   localparam int SUM_W    = SPEED_W + $clog2(AVG_DEPTH + 1);

   // Target numerator is max_speed times a ramp step or a percentage.
   localparam int MULT_W   = 7;
   localparam int DIV_W    = (SPEED_W + MULT_W > SUM_W) ? SPEED_W + MULT_W : SUM_W;
   localparam int DVS_W    = 7;
   localparam int STEP_W   = $clog2(DIV_W + 1);

   localparam int PWM_PERIOD  = 500;
   localparam int RAMP_LOW    = 20;
   localparam int RAMP_HIGH   = 30;
   localparam int RAMP_SPAN   = RAMP_HIGH - RAMP_LOW;
   localparam int DIAL_STEP   = 7;
   localparam int DIAL_MAX_PC = 99;
   localparam int PC_SCALE    = 100;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SOURCE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_READING_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Q8       = 3'd4;

   localparam logic               RST_TARGET_SOURCE = 1'b1;
   localparam logic [SPEED_W-1:0] RST_MAX_SPEED     = 12'd2300;
   localparam logic [SPEED_W-1:0] RST_CHANGE_LIMIT  = 12'd3000;
   localparam logic [SPEED_W-1:0] RST_READING_LIMIT = 12'd3000;
   localparam logic [GAIN_W-1:0]  RST_GAIN_Q8       = 8'd51;

endpackage

FILE: sv/fsc_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, DIV_W quotient bits.
// Depends on fsc_pkg for the dividend and divisor widths.
module fsc_serial_div import fsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic              busy,
   output logic [DIV_W-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W:0]    trial;
   logic              fits;

   // The dividend shifts out of the top of quo_ff while quotient bits
   // shift in at the bottom.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/fan_speed_control_tick_top.sv
// Top level of the fan speed control tick: tachometer filter, target,
// proportional drive and moving average. Depends on fsc_pkg and fsc_serial_div.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  tacho_reading, temperature, dial_position
//   rsp_     out        rsp_valid/rsp_ready  pulse_width, target_speed,
//                                            accepted_speed, smoothed_speed
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// Each word is accepted in idle, then passes the filter, update, divide and
// finish states before its result enters the output register; the two
// bit-serial dividers run side by side for the target and the average. The next
// word is taken while a result still waits in the output register, but its
// finish state holds until the output register is free. Reset clears the
// control state, the configuration to its defaults and the history count;
// history entries are only used once written, so the memory needs no clearing pass.
module fan_speed_control_tick_top import fsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TACHO_W-1:0]     req_tacho_reading,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic [DIAL_W-1:0]      req_dial_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PW_W-1:0]        rsp_pulse_width,
   output logic [SPEED_W-1:0]     rsp_target_speed,
   output logic [SPEED_W-1:0]     rsp_accepted_speed,
   output logic [SPEED_W-1:0]     rsp_smoothed_speed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILTER,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic               src_ff, src_in;
   logic [SPEED_W-1:0] max_ff, max_in;
   logic [SPEED_W-1:0] change_ff, change_in;
   logic [SPEED_W-1:0] rlimit_ff, rlimit_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;

   // Captured input word.
   logic [TACHO_W-1:0]       tacho_ff, tacho_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [DIAL_W-1:0]        dial_ff, dial_in;

   // Controller state.
   logic [SPEED_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DIV_W-1:0]   prod_ff, prod_in;
   logic [DVS_W-1:0]   tdvs_ff, tdvs_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PW_W-1:0]    pw_ff, pw_in;
   logic [SPEED_W-1:0] tgt_ff, tgt_in;
   logic [SPEED_W-1:0] acc_ff, acc_in;
   logic [SPEED_W-1:0] avg_ff, avg_in;

   // History memory.
   logic [SPEED_W-1:0] hist_mem [AVG_DEPTH];
   logic [SPEED_W-1:0] hist_rd_ff;

   // Datapath helpers.
   logic [TACHO_W-1:0] cur_wide;
   logic [TACHO_W-1:0] diff;
   logic               take_reading;
   logic [TEMP_W-1:0]  t_off;
   logic [MULT_W-1:0]  temp_mult;
   logic [10:0]        pc_raw;
   logic [MULT_W-1:0]  dial_mult;
   logic [MULT_W-1:0]  mult;
   logic               full;
   logic [SPEED_W-1:0] tgt_now;
   logic [SPEED_W-1:0] err;
   logic [GAIN_W+SPEED_W-1:0] drive_full;
   logic [SPEED_W-1:0] drive_q;
   logic [PW_W-1:0]    drive_sat;

   // Divider connections.
   logic               div_start;
   logic               tdiv_busy, adiv_busy;
   logic [DIV_W-1:0]   tdiv_quo, adiv_quo;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign div_start = (state_ff == ST_UPDATE);

   // Plausibility filter on the raw tachometer reading.
   assign cur_wide     = {{(TACHO_W-SPEED_W){1'b0}}, cur_ff};
   assign diff         = (tacho_ff > cur_wide) ? tacho_ff - cur_wide : cur_wide - tacho_ff;
   assign take_reading = (diff < {{(TACHO_W-SPEED_W){1'b0}}, change_ff}) &&
                         (tacho_ff < {{(TACHO_W-SPEED_W){1'b0}}, rlimit_ff});

   // Ramp step 0..RAMP_SPAN; with divisor RAMP_SPAN the top step gives max exactly.
   assign t_off = 8'(temp_ff) - 8'(RAMP_LOW);
   always_comb begin
      if (temp_ff <= RAMP_LOW) begin
         temp_mult = '0;
      end else if (temp_ff >= RAMP_HIGH) begin
         temp_mult = MULT_W'(RAMP_SPAN);
      end else begin
         temp_mult = t_off[MULT_W-1:0];
      end
   end

   assign pc_raw    = 11'(dial_ff) * 11'(DIAL_STEP);
   assign dial_mult = (pc_raw > 11'(DIAL_MAX_PC)) ? MULT_W'(DIAL_MAX_PC)
                                                 : pc_raw[MULT_W-1:0];
   assign mult      = src_ff ? temp_mult : dial_mult;

   // History bookkeeping.
   assign full = (count_ff == CNT_W'(AVG_DEPTH));

   // Proportional drive from the target quotient.
   assign tgt_now    = tdiv_quo[SPEED_W-1:0];
   assign err        = tgt_now - cur_ff;
   assign drive_full = (GAIN_W+SPEED_W)'(gain_ff) * (GAIN_W+SPEED_W)'(err);
   assign drive_q    = drive_full[GAIN_W+SPEED_W-1:GAIN_W];
   always_comb begin
      if (tgt_now <= cur_ff) begin
         drive_sat = '0;
      end else if (drive_q > SPEED_W'(PWM_PERIOD)) begin
         drive_sat = PW_W'(PWM_PERIOD);
      end else begin
         drive_sat = drive_q[PW_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      max_in       = max_ff;
      change_in    = change_ff;
      rlimit_in    = rlimit_ff;
      gain_in      = gain_ff;
      tacho_in     = tacho_ff;
      temp_in      = temp_ff;
      dial_in      = dial_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      tdvs_in      = tdvs_ff;
      rsp_valid_in = rsp_valid_ff;
      pw_in        = pw_ff;
      tgt_in       = tgt_ff;
      acc_in       = acc_ff;
      avg_in       = avg_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_SOURCE: src_in    = csr_data[0];
            CSR_MAX_SPEED:     max_in    = csr_data[SPEED_W-1:0];
            CSR_CHANGE_LIMIT:  change_in = csr_data[SPEED_W-1:0];
            CSR_READING_LIMIT: rlimit_in = csr_data[SPEED_W-1:0];
            CSR_GAIN_Q8:       gain_in   = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               tacho_in = req_tacho_reading;
               temp_in  = req_temperature;
               dial_in  = req_dial_position;
               state_in = ST_FILTER;
            end
         end
         ST_FILTER: begin
            if (take_reading) begin
               cur_in = tacho_ff[SPEED_W-1:0];
            end
            prod_in  = DIV_W'(max_ff) * DIV_W'(mult);
            tdvs_in  = src_ff ? DVS_W'(RAMP_SPAN) : DVS_W'(PC_SCALE);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // The oldest entry leaves the sum only once the history is full.
            sum_in   = sum_ff - (full ? SUM_W'(hist_rd_ff) : '0) + SUM_W'(cur_ff);
            count_in = full ? count_ff : count_ff + 1'b1;
            slot_in  = (slot_ff == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!tdiv_busy && !adiv_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               pw_in        = drive_sat;
               tgt_in       = tgt_now;
               acc_in       = cur_ff;
               avg_in       = adiv_quo[SPEED_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= RST_TARGET_SOURCE;
         max_ff       <= RST_MAX_SPEED;
         change_ff    <= RST_CHANGE_LIMIT;
         rlimit_ff    <= RST_READING_LIMIT;
         gain_ff      <= RST_GAIN_Q8;
         cur_ff       <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         max_ff       <= max_in;
         change_ff    <= change_in;
         rlimit_ff    <= rlimit_in;
         gain_ff      <= gain_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tacho_ff <= tacho_in;
      temp_ff  <= temp_in;
      dial_ff  <= dial_in;
      prod_ff  <= prod_in;
      tdvs_ff  <= tdvs_in;
      pw_ff    <= pw_in;
      tgt_ff   <= tgt_in;
      acc_ff   <= acc_in;
      avg_ff   <= avg_in;
   end

   // The entry about to be replaced is read in the filter state, the cycle before its write.
   always_ff @(posedge clock) begin
      if (state_ff == ST_FILTER) begin
         hist_rd_ff <= hist_mem[slot_ff];
      end
      if (state_ff == ST_UPDATE) begin
         hist_mem[slot_ff] <= cur_ff;
      end
   end

   fsc_serial_div u_target_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (tdvs_ff),
      .busy     (tdiv_busy),
      .quotient (tdiv_quo)
   );

   fsc_serial_div u_average_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_W'(sum_in)),
      .divisor  (DVS_W'(count_in)),
      .busy     (adiv_busy),
      .quotient (adiv_quo)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pulse_width    = pw_ff;
   assign rsp_target_speed   = tgt_ff;
   assign rsp_accepted_speed = acc_ff;
   assign rsp_smoothed_speed = avg_ff;

   // No new word may enter while either divider is still working.
   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (tdiv_busy || adiv_busy) |-> !req_ready)
      else $error("input ready while a divider is busy");

   // The history count saturates at the averaging depth.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(AVG_DEPTH))
      else $error("history count beyond depth");

   // The accepted speed changes only in the filter step.
   a_speed_changes_in_filter: assert property (@(posedge clock) disable iff (reset)
      !$stable(cur_ff) |-> $past(state_ff == ST_FILTER))
      else $error("accepted speed changed outside the filter step");

   // A result appears only from the final step of a word.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the final step");

endmodule

FILE: bench/fan_speed_control_tick_top_test.sv
// Self-checking bench for fan_speed_control_tick_top: drives control ticks with random
// idling and stalls and predicts each result word from a model of the tick arithmetic.
// Depends on fsc_pkg and the fan_speed_control_tick_top RTL.
module fan_speed_control_tick_top_test import fsc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD = 10;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TICK_LATENCY = DIV_W + 4;

   typedef struct packed {
      logic [TACHO_W-1:0] tacho;
      logic [TEMP_W-1:0]  temp;
      logic [DIAL_W-1:0]  dial;
   } tick_word_type;

   typedef struct packed {
      logic [PW_W-1:0]    pulse_width;
      logic [SPEED_W-1:0] target_speed;
      logic [SPEED_W-1:0] accepted_speed;
      logic [SPEED_W-1:0] smoothed_speed;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [TACHO_W-1:0]       req_tacho_reading = '0;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic [DIAL_W-1:0]        req_dial_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [PW_W-1:0]          rsp_pulse_width;
   logic [SPEED_W-1:0]       rsp_target_speed;
   logic [SPEED_W-1:0]       rsp_accepted_speed;
   logic [SPEED_W-1:0]       rsp_smoothed_speed;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // Predictor copy of the configuration and the controller state.
   logic               cfg_target_source = RST_TARGET_SOURCE;
   logic [SPEED_W-1:0] cfg_max_speed     = RST_MAX_SPEED;
   logic [SPEED_W-1:0] cfg_change_limit  = RST_CHANGE_LIMIT;
   logic [SPEED_W-1:0] cfg_reading_limit = RST_READING_LIMIT;
   logic [GAIN_W-1:0]  cfg_gain          = RST_GAIN_Q8;

   logic [SPEED_W-1:0] speed_now = '0;
   int unsigned        speed_log [AVG_DEPTH];
   int unsigned        log_count = 0;
   int unsigned        log_slot = 0;
   int unsigned        log_sum = 0;

   tick_word_type   tick_backlog [$];
   tick_result_type predicted_ticks [$];

   int req_idle_pct = 38;
   int rsp_stall_pct = 38;
   int fail_count = 0;
   int cycle_count = 0;

   fan_speed_control_tick_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_tacho_reading  (req_tacho_reading),
      .req_temperature    (req_temperature),
      .req_dial_position  (req_dial_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pulse_width    (rsp_pulse_width),
      .rsp_target_speed   (rsp_target_speed),
      .rsp_accepted_speed (rsp_accepted_speed),
      .rsp_smoothed_speed (rsp_smoothed_speed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Filters the reading, forms target and drive, then updates the moving average.
   function automatic tick_result_type fan_tick_outputs(logic [TACHO_W-1:0] reading,
                                                        logic [TEMP_W-1:0] temp_raw,
                                                        logic [DIAL_W-1:0] dial);
      int unsigned     jump;
      int              degrees;
      int unsigned     target;
      int unsigned     pct;
      int unsigned     drive_val;
      int unsigned     mean;
      tick_result_type res;
      jump = (reading > speed_now) ? reading - speed_now : speed_now - reading;
      if (jump < cfg_change_limit && reading < cfg_reading_limit) begin
         speed_now = reading[SPEED_W-1:0];
      end
      degrees = $signed(temp_raw);
      if (cfg_target_source) begin
         if (degrees <= RAMP_LOW) begin
            target = 0;
         end else if (degrees >= RAMP_HIGH) begin
            target = int'(cfg_max_speed);
         end else begin
            target = (int'(cfg_max_speed) * (degrees - RAMP_LOW)) / RAMP_SPAN;
         end
      end else begin
         pct = int'(dial) * DIAL_STEP;
         if (pct > DIAL_MAX_PC) begin
            pct = DIAL_MAX_PC;
         end
         target = (int'(cfg_max_speed) * pct) / PC_SCALE;
      end
      if (target <= speed_now) begin
         drive_val = 0;
      end else begin
         drive_val = (int'(cfg_gain) * (target - speed_now)) >> GAIN_W;
         if (drive_val > PWM_PERIOD) begin
            drive_val = PWM_PERIOD;
         end
      end
      // Only a full history evicts, so an unwritten entry is never read.
      if (log_count >= AVG_DEPTH) begin
         log_sum -= speed_log[log_slot];
      end else begin
         log_count++;
      end
      speed_log[log_slot] = int'(speed_now);
      log_sum += speed_now;
      log_slot = (log_slot + 1) % AVG_DEPTH;
      mean = log_sum / log_count;
      res.pulse_width    = drive_val[PW_W-1:0];
      res.target_speed   = target[SPEED_W-1:0];
      res.accepted_speed = speed_now;
      res.smoothed_speed = mean[SPEED_W-1:0];
      return res;
   endfunction

   // Sender: predicts each word as it is taken, then offers the next one or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            tick_result_type p;
            p = fan_tick_outputs(req_tacho_reading, req_temperature, req_dial_position);
            predicted_ticks = {predicted_ticks, p};
         end
         if (!req_valid || req_ready) begin
            if (tick_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               tick_word_type w;
               w = tick_backlog[0];
               tick_backlog.delete(0);
               req_valid         <= 1'b1;
               req_tacho_reading <= w.tacho;
               req_temperature   <= w.temp;
               req_dial_position <= w.dial;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result word against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_ticks.size() == 0) begin
               $error("result word with no prediction waiting");
               fail_count++;
            end else begin
               tick_result_type exp_r;
               exp_r = predicted_ticks[0];
               predicted_ticks.delete(0);
               if (rsp_pulse_width !== exp_r.pulse_width) begin
                  $error("pulse_width: expected %0d, actual %0d",
                         exp_r.pulse_width, rsp_pulse_width);
                  fail_count++;
               end
               if (rsp_target_speed !== exp_r.target_speed) begin
                  $error("target_speed: expected %0d, actual %0d",
                         exp_r.target_speed, rsp_target_speed);
                  fail_count++;
               end
               if (rsp_accepted_speed !== exp_r.accepted_speed) begin
                  $error("accepted_speed: expected %0d, actual %0d",
                         exp_r.accepted_speed, rsp_accepted_speed);
                  fail_count++;
               end
               if (rsp_smoothed_speed !== exp_r.smoothed_speed) begin
                  $error("smoothed_speed: expected %0d, actual %0d",
                         exp_r.smoothed_speed, rsp_smoothed_speed);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("fan_speed_control_tick_top_test: FAIL");
         $finish;
      end
   end

   task automatic queue_tick(int unsigned tacho, int temp, int unsigned dial);
      tick_word_type w;
      w.tacho = tacho[TACHO_W-1:0];
      w.temp  = temp[TEMP_W-1:0];
      w.dial  = dial[DIAL_W-1:0];
      tick_backlog = {tick_backlog, w};
   endtask

   // Returns once every queued word has been taken and every result has come back.
   task automatic wait_drained();
      @(negedge clock);
      while (tick_backlog.size() != 0 || req_valid || predicted_ticks.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         CSR_TARGET_SOURCE: cfg_target_source = value[0];
         CSR_MAX_SPEED:     cfg_max_speed     = value;
         CSR_CHANGE_LIMIT:  cfg_change_limit  = value;
         CSR_READING_LIMIT: cfg_reading_limit = value;
         CSR_GAIN_Q8:       cfg_gain          = value[GAIN_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Extremes in a third to half of the picks; limits otherwise lean high so readings get through.
   task automatic random_config();
      int unsigned pick;
      pick = $urandom_range(3);
      write_csr(CSR_TARGET_SOURCE, (pick == 0) ? $urandom_range(4095) : $urandom_range(1));
      pick = $urandom_range(3);
      write_csr(CSR_MAX_SPEED, (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(4095));
      pick = $urandom_range(5);
      write_csr(CSR_CHANGE_LIMIT,
                (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(500, 4095));
      pick = $urandom_range(5);
      write_csr(CSR_READING_LIMIT,
                (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(1000, 4095));
      pick = $urandom_range(4);
      write_csr(CSR_GAIN_Q8, (pick == 0) ? 0 : (pick == 1) ? 255 :
                             (pick == 2) ? $urandom_range(4095) : $urandom_range(255));
   endtask

   task automatic queue_random_ticks(int n);
      int unsigned tacho;
      int          temp;
      int unsigned dial;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0:       tacho = $urandom_range(65535);
            1:       tacho = $urandom_range(2900, 3100);
            default: tacho = $urandom_range(4095);
         endcase
         temp = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15, 35);
         dial = ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(16);
         queue_tick(tacho, temp, dial);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: temperature ramp, both limits at 3000.
      queue_tick(0, -128, 0);
      queue_tick(1000, 20, 0);
      queue_tick(1500, 21, 0);
      queue_tick(2999, 25, 0);
      queue_tick(3000, 29, 0);
      queue_tick(65535, 30, 0);
      queue_tick(100, 127, 255);
      queue_tick(2500, 26, 0);
      wait_drained();

      // Dial target at full-scale max speed with the largest gain, so the larger dial settings saturate the drive.
      write_csr(CSR_TARGET_SOURCE, 0);
      write_csr(CSR_MAX_SPEED, 4095);
      write_csr(CSR_GAIN_Q8, 255);
      queue_tick(0, 0, 0);
      queue_tick(0, 0, 1);
      queue_tick(0, 0, 14);
      queue_tick(0, 0, 15);
      queue_tick(4000, 0, 255);
      queue_tick(4095, -1, 128);
      wait_drained();

      // Zero gain and zero limits: nothing is accepted and the drive stays at zero.
      write_csr(CSR_GAIN_Q8, 0);
      write_csr(CSR_CHANGE_LIMIT, 0);
      queue_tick(10, 0, 7);
      queue_tick(4095, 0, 255);
      wait_drained();
      write_csr(CSR_CHANGE_LIMIT, 4095);
      write_csr(CSR_READING_LIMIT, 0);
      wait_drained();
      queue_tick(0, 0, 3);
      queue_tick(1, 0, 9);
      wait_drained();

      // Writes to unused indexes must leave every register as it was.
      for (int k = CSR_GAIN_Q8 + 1; k < 2 ** CSR_IDX_W; k++) begin
         write_csr(k[CSR_IDX_W-1:0], $urandom_range(4095));
      end
      write_csr(CSR_READING_LIMIT, 4095);
      write_csr(CSR_GAIN_Q8, 200);
      queue_tick(1234, 0, 13);
      queue_tick(4094, 0, 100);
      wait_drained();

      for (int phase = 0; phase < 10; phase++) begin
         random_config();
         req_idle_pct  = (phase == 3) ? 0 : 38;
         rsp_stall_pct = (phase == 3) ? 0 : 38;
         if (phase == 6) begin
            // The sender holds off mid-phase until every result has come back.
            queue_random_ticks(50);
            wait_drained();
            queue_random_ticks(50);
         end else begin
            queue_random_ticks(100);
         end
         wait_drained();
      end

      repeat (2 * TICK_LATENCY) @(posedge clock);
      if (fail_count == 0) begin
         $display("fan_speed_control_tick_top_test: PASS");
      end else begin
         $display("fan_speed_control_tick_top_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/fsc_pkg.sv
sv/fsc_serial_div.sv
sv/fan_speed_control_tick_top.sv
bench/fan_speed_control_tick_top_test.sv
